@@ hw/rtl/char_lcd_nibble_write_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the character LCD write sequencer.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LCDNW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdnw: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define LCDNW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdnw: next-cycle check failed");

`endif

@@ hw/rtl/lcdnw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types, codes and timing constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   // request actions
   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_CMD  = 2'd1;
   localparam logic [1:0] ACT_CHAR = 2'd2;
   localparam logic [1:0] ACT_GOTO = 2'd3;

   localparam logic [1:0] ROW_ONE   = 2'd1;
   localparam logic [1:0] ROW_TWO   = 2'd2;
   localparam logic [7:0] ROW1_BASE = 8'h80;
   localparam logic [7:0] ROW2_BASE = 8'hC0;

   localparam logic [3:0] WAKE_NIB_A = 4'h3;
   localparam logic [3:0] WAKE_NIB_B = 4'h2;
   localparam logic [3:0] WAKE_NIB_C = 4'h0;

   // hold times in ms
   localparam logic [4:0] HOLD_POWER_UP = 5'd20;
   localparam logic [4:0] HOLD_WAKE     = 5'd5;
   localparam logic [4:0] HOLD_SHORT    = 5'd2;
   localparam logic [4:0] HOLD_SETTLE   = 5'd0;
   localparam logic [4:0] HOLD_CMD_GAP  = 5'd6;
   localparam logic [4:0] HOLD_CMD_END  = 5'd5;

   localparam logic [2:0] SUB_LAST = 3'd6;
   localparam logic [2:0] IDX_LAST = 3'd4;
   localparam logic [1:0] WAKE_LAST = 2'd2;

   typedef struct packed {
      logic       init;
      logic       rs;
      logic [7:0] data_byte;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      case (idx)
         3'd0:    cmd = 8'h28;
         3'd1:    cmd = 8'h08;
         3'd2:    cmd = 8'h01;
         3'd3:    cmd = 8'h06;
         default: cmd = 8'h0C;
      endcase
      return cmd;
   endfunction

endpackage

@@ hw/rtl/lcdnw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests, decodes the action and turns each one it keeps into one byte job.
// ----------------------------------------------------------------------------
module lcdnw_front import lcdnw_pkg::*; (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // value[7:0], row[9:8], column[17:10]
   input  logic [1:0]  req_tuser,   // action[1:0]
   input  logic        queue_full,
   output logic        push,
   output job_type     push_job
);

   logic [1:0] action;
   logic [7:0] value;
   logic [1:0] row;
   logic [7:0] column;
   logic       keep;
   logic [7:0] row_base;

   assign action = req_tuser;
   assign value  = req_tdata[7:0];
   assign row    = req_tdata[9:8];
   assign column = req_tdata[17:10];

   assign req_tready = !queue_full;

   always_comb begin
      row_base          = (row == ROW_TWO) ? ROW2_BASE : ROW1_BASE;
      keep              = 1'b1;
      push_job.init     = 1'b0;
      push_job.rs       = 1'b0;
      push_job.data_byte = value;
      case (action)
         ACT_INIT: begin
            push_job.init = 1'b1;
         end
         ACT_CMD: begin
            push_job.rs = 1'b0;
         end
         ACT_CHAR: begin
            push_job.rs = 1'b1;
         end
         ACT_GOTO: begin
            // drop gotos to rows that do not exist
            keep               = row inside {ROW_ONE, ROW_TWO};
            push_job.data_byte = 8'(row_base + column);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && req_tready && keep;

endmodule

@@ hw/rtl/lcdnw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_queue
// Small job FIFO between the request decoder and the pin sequencer.
// ----------------------------------------------------------------------------
module lcdnw_queue import lcdnw_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        push_job,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/lcdnw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_back
// Pin sequencer: expands each job into pin snapshots, one per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdnw_back import lcdnw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,   // data_nibble[3:0], enable[4], hold_ms[9:5]
   output logic           rsp_tuser,   // reg_select
   output logic           rsp_tlast    // last
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAKE = 2'd1;
   localparam logic [1:0] PH_BYTE = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic       init_ff, init_in;
   logic       rs_ff, rs_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] wake_ff, wake_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] sub_ff, sub_in;

   logic [3:0] pin_nib_ff, pin_nib_in;
   logic       pin_rs_ff, pin_rs_in;
   logic       pin_en_ff, pin_en_in;

   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_nib_ff;
   logic       out_rs_ff;
   logic       out_en_ff;
   logic [4:0] out_hold_ff;
   logic       out_last_ff;

   logic       adv;
   logic       last_run;
   logic       run_done;
   logic [7:0] cur_byte;
   logic [3:0] snap_nib;
   logic       snap_rs;
   logic       snap_en;
   logic [4:0] snap_hold;

   assign adv      = (phase_ff != PH_IDLE) && (!out_valid_ff || rsp_tready);
   assign cur_byte = init_ff ? init_cmd(idx_ff) : byte_ff;
   assign last_run = (phase_ff == PH_BYTE) && (sub_ff == SUB_LAST)
                     && (!init_ff || idx_ff == IDX_LAST);
   assign run_done = adv && last_run;
   assign pop      = head.valid && ((phase_ff == PH_IDLE) || run_done);

   // snapshot for the current step, and the pin levels left behind
   always_comb begin
      snap_nib   = pin_nib_ff;
      snap_rs    = pin_rs_ff;
      snap_en    = pin_en_ff;
      snap_hold  = HOLD_SETTLE;
      pin_nib_in = pin_nib_ff;
      case (phase_ff)
         PH_WAKE: begin
            case (wake_ff)
               2'd0: begin
                  snap_hold = HOLD_POWER_UP;
               end
               2'd1: begin
                  snap_nib  = WAKE_NIB_A;
                  snap_rs   = 1'b0;
                  snap_hold = HOLD_WAKE;
               end
               default: begin
                  snap_nib  = WAKE_NIB_B;
                  snap_rs   = 1'b0;
                  snap_hold = HOLD_WAKE;
               end
            endcase
            pin_nib_in = (wake_ff == WAKE_LAST) ? WAKE_NIB_C : snap_nib;
         end
         PH_BYTE: begin
            snap_rs = rs_ff;
            case (sub_ff)
               3'd0: begin
                  snap_en   = 1'b0;
                  snap_hold = HOLD_SHORT;
               end
               3'd1: begin
                  snap_nib  = cur_byte[7:4];
                  snap_en   = 1'b0;
                  snap_hold = HOLD_SETTLE;
               end
               3'd2: begin
                  snap_nib  = cur_byte[7:4];
                  snap_en   = 1'b1;
                  snap_hold = HOLD_SHORT;
               end
               3'd3: begin
                  snap_nib  = cur_byte[7:4];
                  snap_en   = 1'b0;
                  snap_hold = rs_ff ? HOLD_SHORT : HOLD_CMD_GAP;
               end
               3'd4: begin
                  snap_nib  = cur_byte[3:0];
                  snap_en   = 1'b0;
                  snap_hold = rs_ff ? HOLD_SHORT : HOLD_SETTLE;
               end
               3'd5: begin
                  snap_nib  = cur_byte[3:0];
                  snap_en   = 1'b1;
                  snap_hold = HOLD_SHORT;
               end
               default: begin
                  snap_nib  = cur_byte[3:0];
                  snap_en   = 1'b0;
                  snap_hold = rs_ff ? HOLD_SHORT : HOLD_CMD_END;
               end
            endcase
            pin_nib_in = snap_nib;
         end
         default: begin
            pin_nib_in = pin_nib_ff;
         end
      endcase
      pin_rs_in = snap_rs;
      pin_en_in = snap_en;
   end

   // step sequencer
   always_comb begin
      phase_in = phase_ff;
      init_in  = init_ff;
      rs_in    = rs_ff;
      byte_in  = byte_ff;
      wake_in  = wake_ff;
      idx_in   = idx_ff;
      sub_in   = sub_ff;
      if (pop) begin
         init_in  = head.job.init;
         rs_in    = head.job.rs;
         byte_in  = head.job.data_byte;
         phase_in = head.job.init ? PH_WAKE : PH_BYTE;
         wake_in  = '0;
         idx_in   = '0;
         sub_in   = '0;
      end else if (run_done) begin
         phase_in = PH_IDLE;
      end else if (adv) begin
         if (phase_ff == PH_WAKE) begin
            if (wake_ff == WAKE_LAST) begin
               phase_in = PH_BYTE;
            end else begin
               wake_in = wake_ff + 1'b1;
            end
         end else if (sub_ff == SUB_LAST) begin
            // advance to the next init command
            idx_in = idx_ff + 1'b1;
            sub_in = '0;
         end else begin
            sub_in = sub_ff + 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
         pin_nib_ff   <= '0;
         pin_rs_ff    <= 1'b0;
         pin_en_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            pin_nib_ff <= pin_nib_in;
            pin_rs_ff  <= pin_rs_in;
            pin_en_ff  <= pin_en_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      init_ff <= init_in;
      rs_ff   <= rs_in;
      byte_ff <= byte_in;
      wake_ff <= wake_in;
      idx_ff  <= idx_in;
      sub_ff  <= sub_in;
      if (adv) begin
         out_nib_ff  <= snap_nib;
         out_rs_ff   <= snap_rs;
         out_en_ff   <= snap_en;
         out_hold_ff <= snap_hold;
         out_last_ff <= last_run;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_hold_ff, out_en_ff, out_nib_ff};
   assign rsp_tuser  = out_rs_ff;
   assign rsp_tlast  = out_last_ff;

   `LCDNW_ASSERT_IMPL(a_strobe_hold, clock, reset, out_valid_ff && out_en_ff, out_hold_ff == HOLD_SHORT)
   `LCDNW_ASSERT_IMPL(a_last_strobe_low, clock, reset, out_valid_ff && out_last_ff, !out_en_ff)
   `LCDNW_ASSERT_NEXT(a_pop_starts_run, clock, reset, pop, phase_ff != PH_IDLE)
   `LCDNW_ASSERT_IMPL(a_step_range, clock, reset, phase_ff == PH_BYTE, (sub_ff <= SUB_LAST) && (idx_ff <= IDX_LAST))

endmodule

@@ hw/rtl/char_lcd_nibble_write_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// 4-bit character LCD pin sequencer: requests in, pin snapshots out.
// ----------------------------------------------------------------------------
// Each request (init, command byte, character byte, cursor goto) becomes a run
// of pin snapshots on the rsp channel, one per cycle while rsp_tready is high,
// with rsp_tlast on the final one. Command, character and goto requests give
// 7 snapshots each, and init gives 38 snapshots.
// Gotos to rows other than 1 and 2 are accepted and produce nothing. The pin
// sequencer emits one snapshot per cycle while the rsp channel is not stalled
// and starts the next queued request right after the last snapshot of the
// current one; when it is idle, an accepted request is written into the queue,
// then taken from it into the step registers, and its first snapshot is then
// loaded into the output register. A request queue of QUEUE_DEPTH entries lets
// requests be accepted while a run is still in progress.
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // value[7:0], row[9:8], column[17:10]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // data_nibble[3:0], enable[4], hold_ms[9:5]
   output logic        rsp_tuser,   // reg_select
   output logic        rsp_tlast    // last
);

   logic           queue_full;
   logic           push;
   job_type        push_job;
   logic           pop;
   queue_head_type head;

   lcdnw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   lcdnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/char_lcd_nibble_write_sequencer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_test
// Self-checking stream test of the 4-bit character LCD pin sequencer.
// ----------------------------------------------------------------------------
// Requests (init, command, character, cursor goto) go in on the req stream.
// A scoreboard keeps its own copy of the held pin levels and builds the pin
// snapshots that each request must produce. Every snapshot taken off the rsp
// stream is checked in order against them. Both streams idle at random, and
// one long rsp hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_test;
   import lcdnw_pkg::*;

   localparam int RANDOM_REQUESTS = 450;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int INIT_COMMANDS = 5;
   localparam logic [7:0] INIT_SEQUENCE [INIT_COMMANDS] =
      '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   class lcd_pin_scoreboard_type;
      typedef struct packed {
         logic [3:0] nibble;
         logic       rs;
         logic       en;
         logic [4:0] hold;
         logic       last;
      } pin_snapshot_type;

      pin_snapshot_type expected_pins[$];
      logic [3:0]    nibble_lvl;
      logic          rs_lvl;
      logic          en_lvl;
      int            errors;
      int            snapshots_checked;
      int            requests_by_action[4];
      int            silent_gotos;

      function new();
         nibble_lvl = 4'h0;
         rs_lvl = 1'b0;
         en_lvl = 1'b0;
         errors = 0;
         snapshots_checked = 0;
         silent_gotos = 0;
         foreach (requests_by_action[i]) requests_by_action[i] = 0;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      function void capture(logic [4:0] hold);
         pin_snapshot_type s;
         s = '{nibble: nibble_lvl, rs: rs_lvl, en: en_lvl, hold: hold, last: 1'b0};
         expected_pins.push_back(s);
      endfunction

      // high nibble then low nibble, each strobed; data path waits less
      function void strobe_byte(logic [7:0] b, logic rs);
         logic is_char;
         is_char = (rs == RS_DATA);
         en_lvl = 1'b0;
         rs_lvl = rs;
         capture(HOLD_SHORT);
         nibble_lvl = b[7:4];
         capture(HOLD_SETTLE);
         en_lvl = 1'b1;
         capture(HOLD_SHORT);
         en_lvl = 1'b0;
         capture(is_char ? HOLD_SHORT : HOLD_CMD_GAP);
         nibble_lvl = b[3:0];
         capture(is_char ? HOLD_SHORT : HOLD_SETTLE);
         en_lvl = 1'b1;
         capture(HOLD_SHORT);
         en_lvl = 1'b0;
         capture(is_char ? HOLD_SHORT : HOLD_CMD_END);
      endfunction

      function void note_request(logic [1:0] action, logic [7:0] value,
                                 logic [1:0] row, logic [7:0] column);
         int            run_start;
         pin_snapshot_type tail;
         run_start = expected_pins.size();
         requests_by_action[action]++;
         case (action)
            ACT_INIT: begin
               capture(HOLD_POWER_UP);
               rs_lvl = RS_COMMAND;
               nibble_lvl = WAKE_NIB_A;
               capture(HOLD_WAKE);
               nibble_lvl = WAKE_NIB_B;
               capture(HOLD_WAKE);
               // last wake nibble is never strobed; it folds into the first command
               nibble_lvl = WAKE_NIB_C;
               for (int k = 0; k < INIT_COMMANDS; k++) begin
                  strobe_byte(INIT_SEQUENCE[k], RS_COMMAND);
               end
            end
            ACT_CMD:  strobe_byte(value, RS_COMMAND);
            ACT_CHAR: strobe_byte(value, RS_DATA);
            default: begin
               if (row == ROW_ONE) begin
                  strobe_byte(ROW1_BASE + column, RS_COMMAND);
               end else if (row == ROW_TWO) begin
                  strobe_byte(ROW2_BASE + column, RS_COMMAND);
               end else begin
                  silent_gotos++;
               end
            end
         endcase
         if (expected_pins.size() > run_start) begin
            tail = expected_pins.pop_back();
            tail.last = 1'b1;
            expected_pins.push_back(tail);
         end
      endfunction

      function void check_snapshot(logic [3:0] nibble, logic rs, logic en,
                                   logic [4:0] hold, logic last);
         pin_snapshot_type e;
         if (expected_pins.size() == 0) begin
            $error("unexpected snapshot: data_nibble %0h reg_select %0b enable %0b",
                   nibble, rs, en);
            errors++;
            return;
         end
         e = expected_pins.pop_front();
         snapshots_checked++;
         if (nibble !== e.nibble) begin
            $error("data_nibble expected %0h actual %0h", e.nibble, nibble);
            errors++;
         end
         if (rs !== e.rs) begin
            $error("reg_select expected %0b actual %0b", e.rs, rs);
            errors++;
         end
         if (en !== e.en) begin
            $error("enable expected %0b actual %0b", e.en, en);
            errors++;
         end
         if (hold !== e.hold) begin
            $error("hold_ms expected %0d actual %0d", e.hold, hold);
            errors++;
         end
         if (last !== e.last) begin
            $error("last expected %0b actual %0b", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   lcd_pin_scoreboard_type board = new();
   bit no_idle = 1'b0;
   bit long_hold_req = 1'b0;

   char_lcd_nibble_write_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(logic [1:0] action, logic [7:0] value,
                               logic [1:0] row, logic [7:0] column);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {6'b0, column, row, value};
      do @(posedge clock); while (!req_tready);
      board.note_request(action, value, row, column);
   endtask

   task automatic send_random_request();
      int         roll;
      logic [1:0] action;
      roll = $urandom_range(0, 99);
      if (roll < 3)       action = ACT_INIT;
      else if (roll < 33) action = ACT_CMD;
      else if (roll < 73) action = ACT_CHAR;
      else                action = ACT_GOTO;
      send_request(action, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      int open_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      open_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            stall_left = LONG_HOLD_CYCLES - 1;
         end else if (open_left > 0) begin
            rsp_tready <= 1'b1;
            open_left--;
         end else begin
            stall_left = pick_gap();
            open_left = $urandom_range(1, 24);
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_snapshot(rsp_tdata[3:0], rsp_tuser, rsp_tdata[4],
                              rsp_tdata[9:5], rsp_tlast);
      end
   end

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every action, wrap and silent goto rows
      send_request(ACT_INIT, 8'h00, 2'd0, 8'h00);
      send_request(ACT_CMD,  8'h00, 2'd0, 8'h00);
      send_request(ACT_CMD,  8'hFF, 2'd3, 8'hFF);
      send_request(ACT_CHAR, 8'h00, 2'd0, 8'h00);
      send_request(ACT_CHAR, 8'hFF, 2'd3, 8'hFF);
      send_request(ACT_CHAR, 8'hA5, 2'd1, 8'h5A);
      send_request(ACT_CHAR, 8'h5A, 2'd2, 8'hA5);
      send_request(ACT_GOTO, 8'h00, 2'd0, 8'h00);
      send_request(ACT_GOTO, 8'hFF, 2'd3, 8'hFF);
      send_request(ACT_GOTO, 8'h00, ROW_ONE, 8'h00);
      send_request(ACT_GOTO, 8'h00, ROW_ONE, 8'hFF);
      send_request(ACT_GOTO, 8'h00, ROW_TWO, 8'h00);
      send_request(ACT_GOTO, 8'h00, ROW_TWO, 8'h40);
      send_request(ACT_GOTO, 8'h00, ROW_TWO, 8'hFF);
      send_request(ACT_GOTO, 8'hFF, ROW_ONE, 8'h7F);
      send_request(ACT_CHAR, 8'h9C, 2'd0, 8'h00);
      // init with character pins still held from the last request
      send_request(ACT_INIT, 8'hFF, 2'd3, 8'hFF);
      send_request(ACT_GOTO, 8'h00, 2'd3, 8'h10);
      send_request(ACT_GOTO, 8'h00, 2'd0, 8'h20);
      send_request(ACT_CMD,  8'h0F, 2'd1, 8'h01);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         no_idle = (i % 120) < 30;
         if (i == 240) long_hold_req = 1'b1;
         send_random_request();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d init, %0d command, %0d character, %0d goto requests",
               board.requests_by_action[ACT_INIT], board.requests_by_action[ACT_CMD],
               board.requests_by_action[ACT_CHAR], board.requests_by_action[ACT_GOTO]);
      $display("(%0d gotos to inactive rows), %0d pin snapshots checked",
               board.silent_gotos, board.snapshots_checked);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
